### hw/rtl/ising_energy_eval_macros.svh
// Assertion macros shared by the queue and back-end RTL files of the energy evaluator.
`ifndef ISING_ENERGY_EVAL_MACROS_SVH
`define ISING_ENERGY_EVAL_MACROS_SVH
`ifndef SYNTH
`define IEE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define IEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define IEE_ASSERT(lbl, clk, rstn, prop, msg)
`define IEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hw/rtl/iee_pkg.sv
package iee_pkg;

  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 9;
  localparam int COEF_IN_W = 16;
  localparam int SPIN_W    = 32;
  localparam int ENERGY_W  = 26;
  localparam int SC_W      = 6;

  localparam logic [CMD_W-1:0] CMD_FIELD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PAIR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;

  localparam logic [SC_W-1:0] SPIN_COUNT_RST = 6'd32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic [INDEX_W-1:0]          table_index;
    logic signed [COEF_IN_W-1:0] coefficient;
    logic [SPIN_W-1:0]           spin_bits;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### hw/rtl/iee_if.sv
interface iee_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [iee_pkg::CMD_W-1:0]               command;
  logic [iee_pkg::INDEX_W-1:0]             table_index;
  logic signed [iee_pkg::COEF_IN_W-1:0]    coefficient;
  logic [iee_pkg::SPIN_W-1:0]              spin_bits;

  modport source (output valid, command, table_index, coefficient, spin_bits, input ready);
  modport sink (input valid, command, table_index, coefficient, spin_bits, output ready);
endinterface

interface iee_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iee_pkg::ENERGY_W-1:0]  energy;

  modport source (output valid, energy, input ready);
  modport sink (input valid, energy, output ready);
endinterface

interface iee_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [iee_pkg::SC_W-1:0]     spin_count;

  modport source (output valid, spin_count, input ready);
  modport sink (input valid, spin_count, output ready);
endinterface

### hw/rtl/iee_front.sv
module iee_front #(
  parameter int MAX_SPINS = 32,
  parameter int N_W       = $clog2(MAX_SPINS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  iee_in_if.sink              in_ch,
  iee_cfg_if.sink             cfg_ch,
  input  iee_pkg::qstat_t     qstat,
  output iee_pkg::push_t      push,
  output logic [N_W-1:0]      n_active
);

  logic [iee_pkg::SC_W-1:0] spin_count_r, spin_count_nxt;
  logic [6:0]               sc_ext, n_ext;
  logic [13:0]              pair_lim, idx_ext;
  logic                     accept, keep;

  assign cfg_ch.ready = 1'b1;
  assign spin_count_nxt = cfg_ch.valid ? cfg_ch.spin_count : spin_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_count_r <= iee_pkg::SPIN_COUNT_RST;
    end else begin
      spin_count_r <= spin_count_nxt;
    end
  end

  // Spin counts above the configured maximum saturate.
  always_comb begin
    sc_ext   = {1'b0, spin_count_r};
    n_ext    = (sc_ext > 7'(MAX_SPINS)) ? 7'(MAX_SPINS) : sc_ext;
    pair_lim = 14'((14'(n_ext) * (14'(n_ext) - 14'd1)) >> 1);
  end

  assign n_active = n_ext[N_W-1:0];
  assign idx_ext  = 14'(in_ch.table_index);

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid & in_ch.ready;

  // Out-of-range loads and the unused command are dropped here.
  always_comb begin
    case (in_ch.command)
      iee_pkg::CMD_FIELD: keep = (idx_ext < 14'(n_ext));
      iee_pkg::CMD_PAIR:  keep = (idx_ext < pair_lim);
      iee_pkg::CMD_EVAL:  keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  always_comb begin
    push.valid          = accept & keep;
    push.op.command     = in_ch.command;
    push.op.table_index = in_ch.table_index;
    push.op.coefficient = in_ch.coefficient;
    push.op.spin_bits   = in_ch.spin_bits;
  end

endmodule

### hw/rtl/iee_queue.sv
`include "ising_energy_eval_macros.svh"

module iee_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  iee_pkg::push_t   push,
  input  logic             pop,
  output iee_pkg::op_t     head,
  output iee_pkg::qstat_t  qstat
);

  localparam int CNT_W = iee_pkg::QPTR_W + 1;

  iee_pkg::op_t                 q_mem [iee_pkg::QUEUE_DEPTH];
  logic [iee_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         do_pop;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == CNT_W'(iee_pkg::QUEUE_DEPTH));
  assign do_pop      = pop & !qstat.empty;
  assign head        = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + iee_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + iee_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.valid) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_mem[wr_ptr_r] <= push.op;
    end
  end

  `IEE_ASSERT(a_no_push_full, clk, rst_n, !(push.valid && qstat.full), "push into full queue")
  `IEE_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(iee_pkg::QUEUE_DEPTH), "count over depth")
  `IEE_ASSERT_NEXT(a_count_up, clk, rst_n, (push.valid && !do_pop),
                   (count_r == $past(count_r) + CNT_W'(1)), "queue count lost a push")

endmodule

### hw/rtl/iee_back.sv
`include "ising_energy_eval_macros.svh"

module iee_back #(
  parameter int MAX_SPINS   = 32,
  parameter int COEFF_WIDTH = 16,
  parameter int N_W         = $clog2(MAX_SPINS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  iee_pkg::op_t     head,
  input  iee_pkg::qstat_t  qstat,
  output logic             pop,
  input  logic [N_W-1:0]   n_active,
  iee_out_if.source        out_ch
);

  localparam int IDX_W      = $clog2(MAX_SPINS);
  localparam int PAIR_DEPTH = MAX_SPINS * (MAX_SPINS - 1) / 2;
  localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int EW         = iee_pkg::ENERGY_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIELD = 3'd1;
  localparam logic [2:0] ST_PAIR  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [COEFF_WIDTH-1:0]        field_mem [MAX_SPINS];
  logic [COEFF_WIDTH-1:0]        pair_mem [PAIR_DEPTH];
  logic signed [COEFF_WIDTH-1:0] field_rd_r, pair_rd_r;

  logic [2:0]                state_r, state_nxt;
  logic [IDX_W-1:0]          i_r, i_nxt, j_r, j_nxt;
  logic [PAIR_AW-1:0]        pa_r, pa_nxt;
  logic [MAX_SPINS-1:0]      spins_r, spins_nxt;
  logic                      vld_r, vld_nxt, add_r, add_nxt, src_r, src_nxt;
  logic signed [EW-1:0]      acc_r, acc_nxt, term;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [EW-1:0]      energy_r, energy_nxt;

  logic [31:0]                        idx_wide;
  logic signed [31:0]                 coef_wide;
  logic [MAX_SPINS+iee_pkg::SPIN_W-1:0] spins_ext;
  logic                               field_we, pair_we;

  assign pop       = (state_r == ST_IDLE) && !qstat.empty;
  assign idx_wide  = 32'(head.table_index);
  assign coef_wide = 32'(head.coefficient);
  assign spins_ext = {{MAX_SPINS{1'b0}}, head.spin_bits};
  assign field_we  = pop && (head.command == iee_pkg::CMD_FIELD);
  assign pair_we   = pop && (head.command == iee_pkg::CMD_PAIR);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.energy = energy_r;

  // Coefficient memories: one write port for loads, one registered read for the scan.
  always_ff @(posedge clk) begin
    if (field_we) begin
      field_mem[idx_wide[IDX_W-1:0]] <= coef_wide[COEFF_WIDTH-1:0];
    end
    field_rd_r <= field_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[idx_wide[PAIR_AW-1:0]] <= coef_wide[COEFF_WIDTH-1:0];
    end
    pair_rd_r <= pair_mem[pa_r];
  end

  // A set spin bit means -1, so a field term adds h when the bit is set and a
  // coupling term adds J when the two bits differ.
  assign term = src_r ? EW'(pair_rd_r) : EW'(field_rd_r);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pa_nxt        = pa_r;
    spins_nxt     = spins_r;
    vld_nxt       = 1'b0;
    add_nxt       = add_r;
    src_nxt       = src_r;
    acc_nxt       = vld_r ? (add_r ? acc_r + term : acc_r - term) : acc_r;
    energy_nxt    = energy_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    case (state_r)
      ST_IDLE: begin
        if (pop && (head.command == iee_pkg::CMD_EVAL)) begin
          spins_nxt = spins_ext[MAX_SPINS-1:0];
          i_nxt     = '0;
          j_nxt     = IDX_W'(1);
          pa_nxt    = '0;
          acc_nxt   = '0;
          state_nxt = (n_active == '0) ? ST_DONE : ST_FIELD;
        end
      end
      ST_FIELD: begin
        vld_nxt = 1'b1;
        add_nxt = spins_r[i_r];
        src_nxt = 1'b0;
        if (N_W'(i_r) == n_active - N_W'(1)) begin
          i_nxt     = '0;
          j_nxt     = IDX_W'(1);
          state_nxt = (n_active >= N_W'(2)) ? ST_PAIR : ST_DRAIN;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      ST_PAIR: begin
        vld_nxt = 1'b1;
        add_nxt = spins_r[i_r] ^ spins_r[j_r];
        src_nxt = 1'b1;
        pa_nxt  = pa_r + PAIR_AW'(1);
        if (N_W'(j_r) == n_active - N_W'(1)) begin
          if (N_W'(i_r) == n_active - N_W'(2)) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + IDX_W'(1);
            j_nxt = i_r + IDX_W'(2);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          energy_nxt    = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pa_r     <= pa_nxt;
    spins_r  <= spins_nxt;
    add_r    <= add_nxt;
    src_r    <= src_nxt;
    acc_r    <= acc_nxt;
    energy_r <= energy_nxt;
  end

  `IEE_ASSERT_NEXT(a_issue_gives_term, clk, rst_n, (state_r == ST_FIELD || state_r == ST_PAIR), vld_r, "issued read produced no term")
  `IEE_ASSERT(a_pair_in_range, clk, rst_n, (state_r != ST_PAIR) || (N_W'(i_r) < N_W'(j_r) && N_W'(j_r) < n_active), "pair counters out of triangle")
  `IEE_ASSERT_NEXT(a_done_loads_out, clk, rst_n, (state_r == ST_DONE && (!out_valid_r || out_ch.ready)), (out_valid_r && state_r == ST_IDLE), "finished energy not presented")

endmodule

### hw/rtl/ising_energy_eval.sv
// Loads reach the coefficient memories when the back end takes them from the queue while idle,
// so an evaluation in progress holds them back. An evaluation, once it leaves the queue, scans
// the field terms of the n active spins, then the n*(n-1)/2 pair terms, then drains and presents
// the energy; the coefficient memories give one read per cycle to the scan. A 4-entry queue buffers.
// Reset (rst_n low, synchronous) clears control state and sets spin_count to 32;
// coefficient memories are not cleared and hold undefined data until written.
module ising_energy_eval #(
  parameter int MAX_SPINS   = 32,
  parameter int COEFF_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  iee_in_if.sink      in_ch,
  iee_out_if.source   out_ch,
  iee_cfg_if.sink     cfg_ch
);

  localparam int N_W = $clog2(MAX_SPINS + 1);

  iee_pkg::push_t   push;
  iee_pkg::op_t     head;
  iee_pkg::qstat_t  qstat;
  logic             pop;
  logic [N_W-1:0]   n_active;

  iee_front #(
    .MAX_SPINS (MAX_SPINS),
    .N_W       (N_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .qstat    (qstat),
    .push     (push),
    .n_active (n_active)
  );

  iee_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  iee_back #(
    .MAX_SPINS   (MAX_SPINS),
    .COEFF_WIDTH (COEFF_WIDTH),
    .N_W         (N_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .n_active (n_active),
    .out_ch   (out_ch)
  );

endmodule
